// ===== hw/rtl/csv_field_tokenizer_top_macros.svh =====
// ----------------------------------------------------------------------------
// csv_field_tokenizer_top_macros.svh
// Assertion shorthands for the CSV tokenizer (clk / rst_n in scope).
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_TOKENIZER_TOP_MACROS_SVH
`define CSV_FIELD_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CSVT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CSVT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/csvt_pkg.sv =====
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  // Default column limit of the first row
  localparam int CSVT_MAX_COLUMNS = 256;

  // Results one input byte can cause, and bundle queue depth
  localparam int CSVT_RES_PER_WORD = 4;
  localparam int CSVT_QDEPTH       = 4;

  // Register indexes of the config channel
  localparam logic [7:0] CFG_DELIM  = 8'd0;
  localparam logic [7:0] CFG_HEADER = 8'd1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CHAR, KIND_FIELD, KIND_ROW, KIND_ERROR
  } kind_t;

  // One result word as seen on the output side
  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] char_value;
    logic       field_missing;
    logic [7:0] column_index;
    logic       in_header_row;
    logic       run_last;
  } csv_res_t;

  // All results of one input byte; the last valid one has run_last set
  typedef csv_res_t [CSVT_RES_PER_WORD-1:0] bundle_t;

endpackage

// ===== hw/rtl/csvt_front.sv =====
// ----------------------------------------------------------------------------
// csvt_front
// Byte classifier: quoting, return hold-back, field and row ends, width check.
// Takes one byte a cycle while the queue is not full and writes its results as one bundle into the queue.
// ----------------------------------------------------------------------------
module csvt_front import csvt_pkg::*; #(
  parameter int MAX_COLUMNS = CSVT_MAX_COLUMNS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_input,
  output logic       in_full,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       q_full,
  output logic       q_wr,
  output bundle_t    q_wdata
);

  localparam int             CW   = $clog2(MAX_COLUMNS + 2);
  localparam logic [CW-1:0]  MAXC = CW'(MAX_COLUMNS);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_UN    = 8'h4E;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LN    = 8'h6E;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_LL    = 8'h6C;

  typedef enum logic [2:0] {
    MM_EMPTY, MM_N, MM_NSL, MM_LN, MM_LNU, MM_LNUL, MM_ACCEPT, MM_NONE
  } mm_t;

  typedef struct packed {
    logic          quoted;
    logic          qheld;
    logic          rheld;
    logic          nonempty;
    logic          first_seen;
    logic [CW-1:0] width;
    logic [CW-1:0] fcount;
    mm_t           mm;
    logic          halted;
  } fst_t;

  // Parser state plus the results gathered so far for this byte
  typedef struct packed {
    fst_t       s;
    bundle_t    r;
    logic [2:0] n;
  } acc_t;

  fst_t       st_r, st_nxt;
  logic [7:0] delim_r;
  logic       hdr_r;
  logic       accept;
  acc_t       acc;

  // Missing-value recognizer: empty, NA, N/A, null
  function automatic mm_t match_next(mm_t s, logic [7:0] c);
    mm_t m;
    case (s)
      MM_EMPTY: m = (c == CH_UN) ? MM_N : ((c == CH_LN) ? MM_LN : MM_NONE);
      MM_N:     m = (c == CH_UA) ? MM_ACCEPT : ((c == CH_SLASH) ? MM_NSL : MM_NONE);
      MM_NSL:   m = (c == CH_UA) ? MM_ACCEPT : MM_NONE;
      MM_LN:    m = (c == CH_LU) ? MM_LNU : MM_NONE;
      MM_LNU:   m = (c == CH_LL) ? MM_LNUL : MM_NONE;
      MM_LNUL:  m = (c == CH_LL) ? MM_ACCEPT : MM_NONE;
      default:  m = MM_NONE;
    endcase
    return m;
  endfunction

  // Low byte of a column count, zero-extended for narrow counters
  function automatic logic [7:0] to_col(logic [CW-1:0] v);
    logic [CW+7:0] e;
    e = {8'd0, v};
    return e[7:0];
  endfunction

  function automatic acc_t put(acc_t a, kind_t k, logic [7:0] ch, logic miss,
                               logic [7:0] col, logic hdr_en);
    csv_res_t x;
    x.result_kind   = k;
    x.char_value    = ch;
    x.field_missing = miss;
    x.column_index  = col;
    x.in_header_row = hdr_en && !a.s.first_seen;
    x.run_last      = 1'b0;
    a.r[a.n[1:0]]   = x;
    a.n             = a.n + 3'd1;
    return a;
  endfunction

  function automatic acc_t field_end(acc_t a, logic hdr_en);
    logic miss;
    miss = ((a.s.mm == MM_EMPTY) || (a.s.mm == MM_ACCEPT)) &&
           !(hdr_en && !a.s.first_seen);
    a = put(a, KIND_FIELD, 8'd0, miss, to_col(a.s.fcount), hdr_en);
    if (a.s.fcount <= MAXC) begin
      a.s.fcount = a.s.fcount + CW'(1);
    end
    a.s.mm = MM_EMPTY;
    return a;
  endfunction

  function automatic acc_t content(acc_t a, logic [7:0] c, logic hdr_en);
    a      = put(a, KIND_CHAR, c, 1'b0, to_col(a.s.fcount), hdr_en);
    a.s.mm = match_next(a.s.mm, c);
    return a;
  endfunction

  function automatic acc_t process_byte(acc_t a, logic [7:0] c, logic [7:0] dl,
                                        logic hdr_en);
    logic done;
    done       = 1'b0;
    a.s.nonempty = 1'b1;
    // resolve a quote seen inside quotes: doubled quote or closing quote
    if (a.s.qheld) begin
      a.s.qheld = 1'b0;
      if (c == CH_QUOTE) begin
        a    = content(a, CH_QUOTE, hdr_en);
        done = 1'b1;
      end else begin
        a.s.quoted = 1'b0;
      end
    end
    if (!done) begin
      if (c == CH_QUOTE) begin
        if (a.s.quoted) begin
          a.s.qheld = 1'b1;
        end else begin
          a.s.quoted = 1'b1;
        end
      end else if ((c == dl) && !a.s.quoted) begin
        a = field_end(a, hdr_en);
      end else begin
        a = content(a, c, hdr_en);
      end
    end
    return a;
  endfunction

  function automatic acc_t end_line(acc_t a, logic hdr_en);
    logic [CW-1:0] n;
    a.s.rheld  = 1'b0;
    a.s.qheld  = 1'b0;
    a.s.quoted = 1'b0;
    if (a.s.nonempty) begin
      a = field_end(a, hdr_en);
      n = a.s.fcount;
      if (!a.s.first_seen) begin
        if (n > MAXC) begin
          a          = put(a, KIND_ERROR, 8'd0, 1'b0, to_col(n), hdr_en);
          a.s.halted = 1'b1;
        end else begin
          a              = put(a, KIND_ROW, 8'd0, 1'b0, to_col(n), hdr_en);
          a.s.width      = n;
          a.s.first_seen = 1'b1;
        end
      end else if (n != a.s.width) begin
        a          = put(a, KIND_ERROR, 8'd0, 1'b0, to_col(n), hdr_en);
        a.s.halted = 1'b1;
      end else begin
        a = put(a, KIND_ROW, 8'd0, 1'b0, to_col(n), hdr_en);
      end
    end
    a.s.fcount   = '0;
    a.s.nonempty = 1'b0;
    a.s.mm       = MM_EMPTY;
    return a;
  endfunction

  // Classify the incoming byte and gather its results
  always_comb begin
    acc   = '0;
    acc.s = st_r;
    if (!st_r.halted) begin
      if (in_data_byte == CH_LF) begin
        acc = end_line(acc, hdr_r);
      end else if (in_data_byte == CH_CR) begin
        if (acc.s.rheld) begin
          acc = process_byte(acc, CH_CR, delim_r, hdr_r);
        end
        acc.s.rheld = 1'b1;
        if (in_end_of_input) begin
          acc = end_line(acc, hdr_r);
        end
      end else begin
        if (acc.s.rheld) begin
          acc.s.rheld = 1'b0;
          acc = process_byte(acc, CH_CR, delim_r, hdr_r);
        end
        acc = process_byte(acc, in_data_byte, delim_r, hdr_r);
        if (in_end_of_input) begin
          acc = end_line(acc, hdr_r);
        end
      end
    end
    // flag the last result of this byte
    if (acc.n != 3'd0) begin
      acc.r[acc.n[1:0] - 2'd1].run_last = 1'b1;
    end
  end

  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign q_wr      = accept && (acc.n != 3'd0);
  assign q_wdata   = acc.r;
  assign st_nxt    = accept ? acc.s : st_r;
  assign cfg_ready = 1'b1;

  // Hold parser state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      delim_r <= 8'd44;
      hdr_r   <= 1'b1;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_DELIM:  delim_r <= cfg_data;
          CFG_HEADER: hdr_r   <= cfg_data[0];
          default:    ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/csvt_queue.sv =====
// ----------------------------------------------------------------------------
// csvt_queue
// Short register queue of result bundles between classifier and serializer.
// ----------------------------------------------------------------------------
module csvt_queue import csvt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr,
  input  bundle_t wdata,
  output logic    full,
  input  logic    rd,
  output bundle_t rdata,
  output logic    empty
);

  localparam int PW = $clog2(CSVT_QDEPTH);
  localparam int CNW = $clog2(CSVT_QDEPTH + 1);

  bundle_t          ent_r [CSVT_QDEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CNW-1:0]   cnt_r;
  logic             do_wr, do_rd;

  assign full  = (cnt_r == CNW'(CSVT_QDEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = ent_r[rp_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == PW'(CSVT_QDEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (do_rd) begin
        rp_r <= (rp_r == PW'(CSVT_QDEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CNW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CNW'(1);
      end
    end
  end

  // Store the incoming bundle
  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wp_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/csvt_back.sv =====
// ----------------------------------------------------------------------------
// csvt_back
// Result serializer: holds one bundle and presents its results one word each.
// ----------------------------------------------------------------------------
module csvt_back import csvt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  bundle_t    q_rdata,
  output logic       q_rd,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_char_value,
  output logic       out_field_missing,
  output logic [7:0] out_column_index,
  output logic       out_in_header_row,
  output logic       out_run_last
);

  localparam int IW = $clog2(CSVT_RES_PER_WORD);

  bundle_t       cur_r;
  logic          cur_vld_r;
  logic [IW-1:0] idx_r;
  csv_res_t      res;
  logic          load;

  assign res  = cur_r[idx_r];
  // take the next bundle when idle or when the last word of this one goes
  assign load = !cur_vld_r || (out_pop && res.run_last);
  assign q_rd = load && !q_empty;

  // Track bundle occupancy and word position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
    end else if (load) begin
      cur_vld_r <= !q_empty;
      idx_r     <= '0;
    end else if (out_pop) begin
      idx_r <= idx_r + IW'(1);
    end
  end

  // Hold the bundle payload
  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur_r <= q_rdata;
    end
  end

  assign out_empty         = !cur_vld_r;
  assign out_result_kind   = res.result_kind;
  assign out_char_value    = res.char_value;
  assign out_field_missing = res.field_missing;
  assign out_column_index  = res.column_index;
  assign out_in_header_row = res.in_header_row;
  assign out_run_last      = res.run_last;

endmodule

// ===== hw/rtl/csv_field_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// csv_field_tokenizer_top: streaming CSV field tokenizer with quote handling.
// Throughput: one byte per cycle while each byte yields at most one word and
// the output is popped; a byte of more words (up to 4) holds the output port.
// A byte's first word is registered in the bundle queue, then the serializer,
// before it can be popped. Input stalls on 4 queued bundles.
// Reset (rst_n low, synchronous): state and queues clear, comma, header on.
// ----------------------------------------------------------------------------
`include "csv_field_tokenizer_top_macros.svh"

module csv_field_tokenizer_top import csvt_pkg::*; #(
  parameter int MAX_COLUMNS = CSVT_MAX_COLUMNS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_input,
  output logic       in_full,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_char_value,
  output logic       out_field_missing,
  output logic [7:0] out_column_index,
  output logic       out_in_header_row,
  output logic       out_run_last
);

  logic    q_wr, q_full, q_rd, q_empty;
  bundle_t q_wdata, q_rdata;

  // Classify bytes
  csvt_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_data_byte    (in_data_byte),
    .in_end_of_input (in_end_of_input),
    .in_full         (in_full),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_full          (q_full),
    .q_wr            (q_wr),
    .q_wdata         (q_wdata)
  );

  // Buffer result bundles
  csvt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Serialize words to the output
  csvt_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_rdata           (q_rdata),
    .q_rd              (q_rd),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_result_kind   (out_result_kind),
    .out_char_value    (out_char_value),
    .out_field_missing (out_field_missing),
    .out_column_index  (out_column_index),
    .out_in_header_row (out_in_header_row),
    .out_run_last      (out_run_last)
  );

  // Classifier never writes a full queue
  `CSVT_ASSERT_IMP(a_no_write_full, q_wr, !q_full, "bundle written into full queue")
  // Queue occupancy stays consistent
  `CSVT_ASSERT_IMP(a_full_xor_empty, 1'b1, !(q_full && q_empty), "queue full and empty")
  // Serializer picks up queued work without a gap
  `CSVT_ASSERT_NXT(a_back_loads, !q_empty, !out_empty, "queued bundle not presented")

endmodule
